// ===== rtl/nmd_pkg.sv =====
`timescale 1ns / 1ps
// nmd_pkg: shared constants and helpers for the nixie multiplex / dimmer controller
// no dependencies; used by the top level and its port checker

package nmd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int STORE_N     = 4;
    localparam int STORE_AW    = 2;
    localparam int POS_W       = ($clog2(DIGIT_COUNT) > STORE_AW) ? $clog2(DIGIT_COUNT)
                                                                   : STORE_AW;

    localparam int BCD_W   = 4;
    localparam int ANODE_W = 4;
    localparam int BYTE_W  = 8;
    localparam int FLASH_W = 13;
    localparam int WDOG_W  = 3;
    localparam int SLOT_W  = 5;
    localparam int DIM_W   = 5;
    localparam int CFG_AW  = 1;

    localparam logic [FLASH_W-1:0] SECOND_TICKS = FLASH_W'(5000);
    localparam logic [FLASH_W-1:0] SLOW_FLASH   = FLASH_W'(2500);
    localparam logic [FLASH_W-1:0] QUICK_BLINK  = FLASH_W'(625);
    localparam int                 FAST_STEPS   = 5000 / 625;
    localparam logic [SLOT_W-1:0]  SLOT_LAST    = SLOT_W'(24);
    localparam logic [DIM_W-1:0]   MAX_DIM      = DIM_W'(18);
    localparam logic [DIM_W-1:0]   DIM_BASE     = DIM_W'(20);
    localparam logic [BCD_W-1:0]   BCD_MAX      = BCD_W'(9);

    localparam logic [BYTE_W-1:0] CMD_DIGIT_LO = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_DIGIT_HI = 8'd4;
    localparam logic [BYTE_W-1:0] CMD_BRIGHT   = 8'd5;
    localparam logic [BYTE_W-1:0] CMD_LIGHT    = 8'd6;
    localparam logic [BYTE_W-1:0] CMD_VERSION  = 8'd7;
    localparam logic [BYTE_W-1:0] CMD_KICK     = 8'd85;

    localparam logic [BYTE_W-1:0] REPLY_BRIGHT = 8'hff;
    localparam logic [BYTE_W-1:0] REPLY_KICK   = 8'd170;

    localparam logic [CFG_AW-1:0] REG_WDOG_LIMIT = 1'b0;
    localparam logic [CFG_AW-1:0] REG_VERSION    = 1'b1;

    localparam logic [WDOG_W-1:0] WDOG_LIMIT_RST = 3'd5;
    localparam logic [BYTE_W-1:0] VERSION_RST    = 8'h10;

    // dim slots = clamp(20 - 2*b, 0, 18)
    function automatic logic [DIM_W-1:0] f_dim(input logic [BYTE_W-1:0] b);
        logic [DIM_W-1:0] res;
        if (b == '0) begin
            res = MAX_DIM;
        end else if (b >= 8'd10) begin
            res = '0;
        end else begin
            res = DIM_BASE - {b[3:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ===== rtl/nixie_mux_dimmer_spi_ctrl.sv =====
`timescale 1ns / 1ps
// nixie_mux_dimmer_spi_ctrl: four-digit tube multiplexer, dimmer, command decoder, watchdog
// depends on nmd_pkg

// Each beat is a 200 us tick (kind 0) or a received serial byte (kind 1) and yields
// exactly one result beat. All work for a beat is done in the cycle it is accepted and
// lands in the result registers, so one beat per clock is sustained; the only limit is
// the single result register, which frees when the result beat is taken. Commands come
// in byte pairs: 1-4 digit read/write, 5 brightness, 6 light reading, 7 version, 85 kick.
// The display latches and status levels are reported on every result beat.

module nixie_mux_dimmer_spi_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nmd_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  logic [nmd_pkg::BYTE_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [nmd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic [nmd_pkg::BYTE_W-1:0]  i_light_level,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [nmd_pkg::BCD_W-1:0]   o_bcd_code,
    output logic [nmd_pkg::ANODE_W-1:0] o_anode_select,
    output logic                        o_hv_on,
    output logic                        o_sec_led,
    output logic                        o_test_point,
    output logic [nmd_pkg::BYTE_W-1:0]  o_reply_byte,
    output logic                        o_reply_loaded
);
    import nmd_pkg::*;

    logic [WDOG_W-1:0]  r_wlimit;
    logic [BYTE_W-1:0]  r_version;

    logic [FLASH_W-1:0] r_flash, n_flash;
    logic [WDOG_W-1:0]  r_wsecs, n_wsecs;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [BYTE_W-1:0]  r_store [STORE_N];
    logic [BYTE_W-1:0]  n_store [STORE_N];
    logic [BYTE_W-1:0]  r_bright, n_bright;
    logic [DIM_W-1:0]   r_dim, n_dim;
    logic               r_phase, n_phase;
    logic [BYTE_W-1:0]  r_held, n_held;
    logic               r_led, n_led;
    logic               r_test, n_test;
    logic               r_hv, n_hv;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [ANODE_W-1:0] r_anode, n_anode;
    logic [BYTE_W-1:0]  r_reply, n_reply;
    logic               r_loaded, n_loaded;
    logic               r_out_valid;

    logic               w_accept;
    logic               w_expired;
    logic [FLASH_W-1:0] w_flash_inc;
    logic               w_fast_hit;
    logic               w_slow_hit;
    logic [SLOT_W-1:0]  w_slot_inc;
    logic [BYTE_W-1:0]  w_cur_digit;
    logic               w_pos_lit;
    logic               w_first;
    logic [BYTE_W-1:0]  w_cmd;
    logic [STORE_AW-1:0] w_cmd_idx;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_expired   = r_wsecs >= r_wlimit;
    assign w_flash_inc = r_flash + 1'b1;
    assign w_slow_hit  = (w_flash_inc == SLOW_FLASH) || (w_flash_inc == SECOND_TICKS);
    assign w_slot_inc  = r_slot + 1'b1;
    assign w_cur_digit = r_store[r_pos[STORE_AW-1:0]];
    assign w_pos_lit   = (int'(r_pos) < STORE_N) && (w_cur_digit <= {4'd0, BCD_MAX});

    assign w_first   = !r_phase;
    assign w_cmd     = w_first ? i_rx_byte : r_held;
    assign w_cmd_idx = STORE_AW'(w_cmd - CMD_DIGIT_LO);

    always_comb begin
        w_fast_hit = 1'b0;
        for (int k = 1; k <= FAST_STEPS; k++) begin
            if (w_flash_inc == FLASH_W'(k * int'(QUICK_BLINK))) begin
                w_fast_hit = 1'b1;
            end
        end
    end

    always_comb begin
        n_flash  = r_flash;
        n_wsecs  = r_wsecs;
        n_slot   = r_slot;
        n_pos    = r_pos;
        n_store  = r_store;
        n_bright = r_bright;
        n_dim    = r_dim;
        n_phase  = r_phase;
        n_held   = r_held;
        n_led    = r_led;
        n_test   = r_test;
        n_hv     = r_hv;
        n_bcd    = r_bcd;
        n_anode  = r_anode;
        n_reply  = '0;
        n_loaded = 1'b0;

        if (!i_kind) begin
            n_hv = !(w_expired || (r_bright == '0));
            // flash and watchdog seconds
            n_flash = w_flash_inc;
            if (w_expired ? w_fast_hit : w_slow_hit) begin
                n_led = !r_led;
            end
            if (w_flash_inc == SECOND_TICKS) begin
                n_flash = '0;
                if (!w_expired) begin
                    n_wsecs = r_wsecs + 1'b1;
                end
            end
            // digit slot
            n_slot = w_slot_inc;
            if (r_slot == SLOT_LAST) begin
                n_anode = '0;
                n_slot  = '0;
                n_pos   = (r_pos == POS_W'(DIGIT_COUNT - 1)) ? '0 : r_pos + 1'b1;
            end else if ((w_slot_inc == r_dim + 1'b1) && w_pos_lit) begin
                n_bcd   = w_cur_digit[BCD_W-1:0];
                n_anode = ANODE_W'(1) << r_pos[STORE_AW-1:0];
            end
            n_test = !r_test;
        end else begin
            if (w_first) begin
                n_held = i_rx_byte;
            end
            case (w_cmd) inside
                [CMD_DIGIT_LO:CMD_DIGIT_HI]: begin
                    if (w_first) begin
                        n_reply  = r_store[w_cmd_idx];
                        n_loaded = 1'b1;
                    end else begin
                        n_store[w_cmd_idx] = i_rx_byte;
                    end
                end
                CMD_BRIGHT: begin
                    if (w_first) begin
                        n_reply  = REPLY_BRIGHT;
                        n_loaded = 1'b1;
                        n_dim    = f_dim(r_bright);
                    end else begin
                        n_bright = i_rx_byte;
                        n_dim    = f_dim(i_rx_byte);
                    end
                end
                CMD_LIGHT: begin
                    if (w_first) begin
                        n_reply  = i_light_level;
                        n_loaded = 1'b1;
                    end
                end
                CMD_VERSION: begin
                    if (w_first) begin
                        n_reply  = r_version;
                        n_loaded = 1'b1;
                    end
                end
                CMD_KICK: begin
                    if (w_first) begin
                        n_reply  = REPLY_KICK;
                        n_loaded = 1'b1;
                        n_wsecs  = '0;
                    end
                end
                default: begin
                end
            endcase
            n_phase = !r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlimit <= WDOG_LIMIT_RST;
            r_version <= VERSION_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WDOG_LIMIT: r_wlimit  <= i_cfg_wdata[WDOG_W-1:0];
                REG_VERSION:    r_version <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash     <= '0;
            r_wsecs     <= '0;
            r_slot      <= '0;
            r_pos       <= '0;
            for (int i = 0; i < STORE_N; i++) begin
                r_store[i] <= '0;
            end
            r_bright    <= 8'd1;
            r_dim       <= MAX_DIM;
            r_phase     <= 1'b0;
            r_held      <= '0;
            r_led       <= 1'b1;
            r_test      <= 1'b0;
            r_hv        <= 1'b0;
            r_bcd       <= '0;
            r_anode     <= '0;
            r_reply     <= '0;
            r_loaded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_flash  <= n_flash;
                r_wsecs  <= n_wsecs;
                r_slot   <= n_slot;
                r_pos    <= n_pos;
                r_store  <= n_store;
                r_bright <= n_bright;
                r_dim    <= n_dim;
                r_phase  <= n_phase;
                r_held   <= n_held;
                r_led    <= n_led;
                r_test   <= n_test;
                r_hv     <= n_hv;
                r_bcd    <= n_bcd;
                r_anode  <= n_anode;
                r_reply  <= n_reply;
                r_loaded <= n_loaded;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bcd_code     = r_bcd;
    assign o_anode_select = r_anode;
    assign o_hv_on        = r_hv;
    assign o_sec_led      = r_led;
    assign o_test_point   = r_test;
    assign o_reply_byte   = r_reply;
    assign o_reply_loaded = r_loaded;

endmodule

// ===== rtl/nmd_port_chk.sv =====
`timescale 1ns / 1ps
// nmd_port_chk: port-level checks for nixie_mux_dimmer_spi_ctrl, bound to the top level
// depends on nmd_pkg

module nmd_port_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        i_kind,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [nmd_pkg::ANODE_W-1:0] o_anode_select,
    input logic [nmd_pkg::BYTE_W-1:0]  o_reply_byte,
    input logic                        o_reply_loaded
);
    import nmd_pkg::*;

    // output slot free means input side can take a beat
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // a tick beat never loads a reply
    a_tick_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_kind) |=> (o_out_valid && !o_reply_loaded))
        else $error("tick beat loaded a reply");

    a_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reply_loaded) |-> (o_reply_byte == '0))
        else $error("reply byte set without load");

    a_anode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_anode_select))
        else $error("more than one anode lit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_reply_byte)
                                           && $stable(o_anode_select)))
        else $error("stalled result beat changed");

endmodule

bind nixie_mux_dimmer_spi_ctrl nmd_port_chk u_nmd_port_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_kind         (i_kind),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_anode_select (o_anode_select),
    .o_reply_byte   (o_reply_byte),
    .o_reply_loaded (o_reply_loaded)
);
